[hdl/lsac_pkg.sv]
// Shared types and constants for the linear-space alignment cost row.
package lsac_pkg;

  // Operation carried with each input word.
  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_QUERY  = 2'd2,
    FUNC_READ   = 2'd3
  } func_e;

  // Configuration register indexes.
  localparam int unsigned   CFG_IDX_W      = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_COST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_HIGH = 2'd2;

  localparam int unsigned   GAP_W          = 8;
  localparam int unsigned   CFG_DATA_W     = 64;
  localparam int unsigned   TABLE_W        = 2 * CFG_DATA_W;
  localparam int unsigned   SYM_W          = 2;

  localparam logic [GAP_W-1:0]      GAP_COST_RST   = 8'd30;
  localparam logic [CFG_DATA_W-1:0] TABLE_LOW_RST  = 64'd3491979035099033088;
  localparam logic [CFG_DATA_W-1:0] TABLE_HIGH_RST = 64'd31015429568755248;

  // Control part of a word travelling down the cell chain.
  typedef struct packed {
    logic  valid;
    func_e kind;   // append, query or read
    logic  init;   // no query yet since start: use the gap-only row
    logic  oor;    // read column beyond the reference length
    logic  ovf;    // an append was dropped before this read
  } tok_ctl_t;

endpackage

[hdl/lsac_cell.sv]
// One cell of the cost row: holds one reference symbol and one row cost.
module lsac_cell import lsac_pkg::*; #(
  parameter int unsigned COL_W     = 11,
  parameter int unsigned COST_BITS = 20,
  parameter int unsigned CELL_IDX  = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [GAP_W-1:0]     gap_i,
  input  logic [TABLE_W-1:0]   table_i,
  input  tok_ctl_t             ctl_i,
  input  logic [SYM_W-1:0]     sym_i,
  input  logic [COL_W-1:0]     col_i,
  input  logic [COST_BITS-1:0] diag_i,
  input  logic [COST_BITS-1:0] left_i,
  output tok_ctl_t             ctl_o,
  output logic [SYM_W-1:0]     sym_o,
  output logic [COL_W-1:0]     col_o,
  output logic [COST_BITS-1:0] diag_o,
  output logic [COST_BITS-1:0] left_o
);

  function automatic logic [COST_BITS-1:0] sat_add(input logic [COST_BITS-1:0] a,
                                                   input logic [COST_BITS-1:0] b);
    logic [COST_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[COST_BITS] ? '1 : s[COST_BITS-1:0];
  endfunction

  tok_ctl_t             ctl_q;
  logic [SYM_W-1:0]     sym_q;
  logic [COL_W-1:0]     col_q;
  logic [COST_BITS-1:0] diag_q, left_q, left_d;
  logic [COST_BITS-1:0] cost_q;
  logic [SYM_W-1:0]     ref_q;

  logic [COST_BITS-1:0] gap_ext, up, via_diag, via_up, via_left, best;
  logic [7:0]           mm;
  logic                 hit, is_query, is_read, is_append;

  assign gap_ext   = COST_BITS'(gap_i);
  assign hit       = (col_i == COL_W'(CELL_IDX));
  assign is_query  = ctl_i.valid && (ctl_i.kind == FUNC_QUERY);
  assign is_read   = ctl_i.valid && (ctl_i.kind == FUNC_READ);
  assign is_append = ctl_i.valid && (ctl_i.kind == FUNC_APPEND);

  // Old cost of this column; before the first query it is the gap-only row.
  assign up = ctl_i.init ? sat_add(diag_i, gap_ext) : cost_q;
  assign mm = table_i[{sym_i, ref_q, 3'b000} +: 8];

  always_comb begin
    via_diag = sat_add(diag_i, COST_BITS'(mm));
    via_up   = sat_add(up, gap_ext);
    via_left = sat_add(left_i, gap_ext);
    best     = via_diag;
    if (via_up < best) begin
      best = via_up;
    end
    if (via_left < best) begin
      best = via_left;
    end
    if (is_query) begin
      left_d = best;
    end else if (is_read && hit && !ctl_i.oor) begin
      left_d = up;
    end else begin
      left_d = left_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sym_q  <= sym_i;
      col_q  <= col_i;
      diag_q <= up;
      left_q <= left_d;
      if (is_query) begin
        cost_q <= best;
      end
      if (is_append && hit) begin
        ref_q <= sym_i;
      end
    end
  end

  assign ctl_o  = ctl_q;
  assign sym_o  = sym_q;
  assign col_o  = col_q;
  assign diag_o = diag_q;
  assign left_o = left_q;

endmodule

[hdl/lsac_head.sv]
// Head of the chain: alignment state, column zero and word issue.
module lsac_head import lsac_pkg::*; #(
  parameter int unsigned MAX_REF_LEN = 1024,
  parameter int unsigned COL_W       = 11,
  parameter int unsigned COST_BITS   = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 accept_i,
  input  func_e                func_i,
  input  logic [SYM_W-1:0]     sym_i,
  input  logic [COL_W-1:0]     col_i,
  input  logic [GAP_W-1:0]     gap_i,
  output tok_ctl_t             ctl_o,
  output logic [SYM_W-1:0]     sym_o,
  output logic [COL_W-1:0]     col_o,
  output logic [COST_BITS-1:0] diag_o,
  output logic [COST_BITS-1:0] left_o
);

  logic [COL_W-1:0]     len_q, len_d;
  logic [COST_BITS-1:0] edge_q, edge_d, edge_next;
  logic                 started_q, started_d;
  logic                 dropped_q, dropped_d;
  logic [COST_BITS:0]   edge_sum;
  logic                 full, drop_append;

  tok_ctl_t             ctl_q, ctl_d;
  logic [SYM_W-1:0]     sym_q;
  logic [COL_W-1:0]     col_q, col_d;
  logic [COST_BITS-1:0] diag_q, left_q, left_d;

  assign full        = (len_q == COL_W'(MAX_REF_LEN));
  assign drop_append = started_q || full;
  assign edge_sum    = {1'b0, edge_q} + (COST_BITS + 1)'(gap_i);
  assign edge_next   = edge_sum[COST_BITS] ? '1 : edge_sum[COST_BITS-1:0];

  always_comb begin
    len_d     = len_q;
    edge_d    = edge_q;
    started_d = started_q;
    dropped_d = dropped_q;
    ctl_d       = '0;
    ctl_d.kind  = func_i;
    ctl_d.init  = !started_q;
    ctl_d.oor   = (col_i > len_q);
    ctl_d.ovf   = dropped_q;
    col_d       = col_i;
    left_d      = '0;
    case (func_i)
      FUNC_START: begin
        len_d     = '0;
        edge_d    = '0;
        started_d = 1'b0;
        dropped_d = 1'b0;
      end
      FUNC_APPEND: begin
        if (drop_append) begin
          dropped_d = 1'b1;
        end else begin
          len_d       = len_q + COL_W'(1);
          ctl_d.valid = accept_i;
          col_d       = len_q + COL_W'(1);   // cell index of the new symbol
        end
      end
      FUNC_QUERY: begin
        edge_d      = edge_next;
        started_d   = 1'b1;
        ctl_d.valid = accept_i;
        left_d      = edge_next;
      end
      FUNC_READ: begin
        ctl_d.valid = accept_i;
        left_d      = (col_i == '0) ? edge_q : '0;
      end
      default: begin
        ctl_d.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q     <= '0;
      edge_q    <= '0;
      started_q <= 1'b0;
      dropped_q <= 1'b0;
      ctl_q     <= '0;
    end else begin
      if (accept_i) begin
        len_q     <= len_d;
        edge_q    <= edge_d;
        started_q <= started_d;
        dropped_q <= dropped_d;
      end
      if (en_i) begin
        ctl_q <= ctl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sym_q  <= sym_i;
      col_q  <= col_d;
      diag_q <= edge_q;    // old cost of column zero
      left_q <= left_d;
    end
  end

  assign ctl_o  = ctl_q;
  assign sym_o  = sym_q;
  assign col_o  = col_q;
  assign diag_o = diag_q;
  assign left_o = left_q;

endmodule

[hdl/linear_space_alignment_cost_row_top.sv]
// Top level: config registers, head, chain of row cells and output register.
// Path: a read word taken on the slave side is registered in the head stage, in all
//   MAX_REF_LEN cells in order and in the output register before it reaches the master side.
// Throughput: one word per cycle; the whole chain holds only while a finished
//   read waits at the tail and the output register is still full.
// Reset: control state, row length and flags clear; config registers load their
//   defaults; stored symbols and row costs stay unknown until written.
module linear_space_alignment_cost_row_top import lsac_pkg::*; #(
  parameter int unsigned MAX_REF_LEN = 1024,
  parameter int unsigned COST_BITS   = 20,
  localparam int unsigned COL_W      = $clog2(MAX_REF_LEN + 1),
  localparam int unsigned DIN_W      = ((SYM_W + COL_W + 7) / 8) * 8,
  localparam int unsigned DOUT_W     = ((COL_W + COST_BITS + 2 + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // slave stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [DIN_W-1:0]      s_axis_tdata,   // symbol, column, zero pad
  input  logic [1:0]            s_axis_tuser,   // func
  // master stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [DOUT_W-1:0]     m_axis_tdata    // read_column, cost, out_of_range,
                                                // overflow, zero pad
);

  // Config registers; the user must issue writes only while the chain is drained (unchecked).
  logic [GAP_W-1:0]      gap_q;
  logic [CFG_DATA_W-1:0] tbl_lo_q, tbl_hi_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q    <= GAP_COST_RST;
      tbl_lo_q <= TABLE_LOW_RST;
      tbl_hi_q <= TABLE_HIGH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_GAP_COST:   gap_q    <= cfg_data_i[GAP_W-1:0];
        CFG_TABLE_LOW:  tbl_lo_q <= cfg_data_i;
        CFG_TABLE_HIGH: tbl_hi_q <= cfg_data_i;
        default: begin
          // unknown index: drop the word
        end
      endcase
    end
  end

  // Chain links: index 0 is the head stage, index g the output of cell g.
  tok_ctl_t             ctl   [0:MAX_REF_LEN];
  logic [SYM_W-1:0]     sym   [0:MAX_REF_LEN];
  logic [COL_W-1:0]     col   [0:MAX_REF_LEN];
  logic [COST_BITS-1:0] diag  [0:MAX_REF_LEN];
  logic [COST_BITS-1:0] left  [0:MAX_REF_LEN];

  logic                 en, accept, tail_read, out_load;

  logic                 out_valid_q, out_valid_d;
  logic [COL_W-1:0]     out_col_q;
  logic [COST_BITS-1:0] out_cost_q;
  logic                 out_oor_q, out_ovf_q;

  // Advance the whole chain unless a read at the tail has nowhere to go.
  assign tail_read = ctl[MAX_REF_LEN].valid && (ctl[MAX_REF_LEN].kind == FUNC_READ);
  assign en        = !(tail_read && out_valid_q && !m_axis_tready);
  assign accept    = s_axis_tvalid && en;
  assign out_load  = en && tail_read;

  assign s_axis_tready = en;

  lsac_head #(
    .MAX_REF_LEN (MAX_REF_LEN),
    .COL_W       (COL_W),
    .COST_BITS   (COST_BITS)
  ) u_head (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .accept_i (accept),
    .func_i   (func_e'(s_axis_tuser)),
    .sym_i    (s_axis_tdata[SYM_W-1:0]),
    .col_i    (s_axis_tdata[SYM_W+COL_W-1:SYM_W]),
    .gap_i    (gap_q),
    .ctl_o    (ctl[0]),
    .sym_o    (sym[0]),
    .col_o    (col[0]),
    .diag_o   (diag[0]),
    .left_o   (left[0])
  );

  // Cell g holds reference symbol g-1 and row cost of column g.
  for (genvar g = 1; g <= MAX_REF_LEN; g++) begin : g_cell
    lsac_cell #(
      .COL_W     (COL_W),
      .COST_BITS (COST_BITS),
      .CELL_IDX  (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .gap_i   (gap_q),
      .table_i ({tbl_hi_q, tbl_lo_q}),
      .ctl_i   (ctl[g-1]),
      .sym_i   (sym[g-1]),
      .col_i   (col[g-1]),
      .diag_i  (diag[g-1]),
      .left_i  (left[g-1]),
      .ctl_o   (ctl[g]),
      .sym_o   (sym[g]),
      .col_o   (col[g]),
      .diag_o  (diag[g]),
      .left_o  (left[g])
    );
  end

  // Output register: a read's captured cost rides in the left-cost lane.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_col_q  <= col[MAX_REF_LEN];
      out_cost_q <= left[MAX_REF_LEN];
      out_oor_q  <= ctl[MAX_REF_LEN].oor;
      out_ovf_q  <= ctl[MAX_REF_LEN].ovf;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = DOUT_W'({out_ovf_q, out_oor_q, out_cost_q, out_col_q});

  // sym and diag leave the last cell unused
  logic unused_tail;
  assign unused_tail = ^{sym[MAX_REF_LEN], diag[MAX_REF_LEN]};

endmodule
